@@ rtl/mbsh_pkg.sv @@
`default_nettype none

package mbsh_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned WordW = 32;

    // Mixing constants of the 32-bit hash.
    localparam logic [WordW-1:0] MixMul    = 32'h5bd1e995;
    localparam int unsigned      MixShift  = 24;
    localparam int unsigned      FinShiftA = 13;
    localparam int unsigned      FinShiftB = 15;

    // Register file of the APB port: one 32-bit register at byte address 0.
    localparam int unsigned ApbAddrW       = 3;
    localparam logic        RegIdxHashSeed = 1'b0;

    // One queued command for the back end. A completed word and a non-empty
    // tail never come together, so they share the data field.
    typedef struct packed {
        logic             start;
        logic [WordW-1:0] init;
        logic             word;
        logic             fin;
        logic             tail;
        logic [WordW-1:0] data;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_K1,
        S_K2,
        S_H1,
        S_H2,
        S_T,
        S_F1,
        S_F2
    } t_back_state;

    typedef struct packed {
        logic pop;
        logic prod_en;
        logic k_en;
        logic hash_fold;
        logic out_load;
    } t_back_ctrl;

endpackage

`default_nettype wire

@@ rtl/mbsh_if.sv @@
`default_nettype none

interface mbsh_item_if import mbsh_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] data_byte;
    logic             has_byte;
    logic [WordW-1:0] msg_len;
    logic             first_item;
    logic             last_item;

    modport source (
        output valid, data_byte, has_byte, msg_len, first_item, last_item,
        input  ready
    );
    modport sink (
        input  valid, data_byte, has_byte, msg_len, first_item, last_item,
        output ready
    );
endinterface

interface mbsh_result_if import mbsh_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [WordW-1:0] hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink (input valid, hash_value, output ready);
endinterface

`default_nettype wire

@@ rtl/mbsh_front.sv @@
`default_nettype none

module mbsh_front import mbsh_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [WordW-1:0] i_seed,
    mbsh_item_if.sink             i_item,
    input  wire logic             i_q_full,
    output logic                  o_q_push,
    output t_cmd                  o_q_cmd
);

    logic [WordW-1:0] r_pw, n_pw;
    logic [1:0]       r_bp, n_bp;

    logic             w_accept;
    logic [WordW-1:0] w_pw_base;
    logic [1:0]       w_bp_base;
    logic [WordW-1:0] w_pw_fill;
    logic             w_word_done;
    t_cmd             w_cmd;

    assign i_item.ready = !i_q_full;
    assign w_accept     = i_item.valid && !i_q_full;

    always_comb begin
        w_pw_base   = i_item.first_item ? '0 : r_pw;
        w_bp_base   = i_item.first_item ? 2'd0 : r_bp;
        w_pw_fill   = w_pw_base
                    | ({{(WordW-ByteW){1'b0}}, i_item.data_byte} << {w_bp_base, 3'b000});
        w_word_done = i_item.has_byte && (w_bp_base == 2'd3);

        n_pw = w_pw_base;
        n_bp = w_bp_base;
        if (i_item.has_byte) begin
            if (w_word_done) begin
                n_pw = '0;
                n_bp = 2'd0;
            end else begin
                n_pw = w_pw_fill;
                n_bp = w_bp_base + 2'd1;
            end
        end

        w_cmd.start = i_item.first_item;
        w_cmd.init  = i_seed ^ i_item.msg_len;
        w_cmd.word  = w_word_done;
        w_cmd.fin   = i_item.last_item;
        w_cmd.tail  = i_item.last_item && (n_bp != 2'd0);
        w_cmd.data  = w_word_done ? w_pw_fill : n_pw;

        // The partial word is dropped once the message has been closed.
        if (i_item.last_item) begin
            n_pw = '0;
            n_bp = 2'd0;
        end
    end

    assign o_q_push = w_accept && (w_cmd.start || w_cmd.word || w_cmd.fin);
    assign o_q_cmd  = w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw <= '0;
            r_bp <= 2'd0;
        end else if (w_accept) begin
            r_pw <= n_pw;
            r_bp <= n_bp;
        end
    end

endmodule

`default_nettype wire

@@ rtl/mbsh_fifo.sv @@
`default_nettype none

module mbsh_fifo import mbsh_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_count;

    logic w_push, w_pop;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/mbsh_back.sv @@
`default_nettype none

module mbsh_back import mbsh_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  t_cmd      i_q_cmd,
    output logic      o_q_pop,
    mbsh_result_if.source o_result
);

    t_back_state r_state, n_state;
    t_cmd        r_cmd;

    logic [WordW-1:0] r_hash;
    logic [WordW-1:0] r_k;
    logic [WordW-1:0] r_prod;
    logic             r_out_valid;
    logic [WordW-1:0] r_out_hash;

    t_back_ctrl       w_ctrl;
    logic [WordW-1:0] w_mul_a;
    logic [WordW-1:0] w_prod;
    logic [WordW-1:0] w_fin_x;
    logic [WordW-1:0] w_result;
    logic             w_out_free;

    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_fin_x    = r_cmd.tail ? r_prod : r_hash;
    assign w_result   = r_prod ^ (r_prod >> FinShiftB);
    assign w_prod     = w_mul_a * MixMul;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_cmd.word) begin
                        n_state = S_K1;
                    end else if (i_q_cmd.fin) begin
                        n_state = i_q_cmd.tail ? S_T : S_F1;
                    end
                end
            end
            S_K1: n_state = S_K2;
            S_K2: n_state = S_H1;
            S_H1: n_state = S_H2;
            S_H2: begin
                if (r_cmd.fin) begin
                    n_state = r_cmd.tail ? S_T : S_F1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_T:  n_state = S_F1;
            S_F1: n_state = S_F2;
            S_F2: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Controls and the operand of the shared multiplier.
    always_comb begin
        w_ctrl  = '0;
        w_mul_a = r_cmd.data;
        case (r_state)
            S_IDLE: w_ctrl.pop = i_q_valid;
            S_K1: begin
                w_mul_a        = r_cmd.data;
                w_ctrl.prod_en = 1'b1;
            end
            S_K2: begin
                w_mul_a        = r_prod ^ (r_prod >> MixShift);
                w_ctrl.prod_en = 1'b1;
            end
            S_H1: begin
                w_mul_a        = r_hash;
                w_ctrl.prod_en = 1'b1;
                w_ctrl.k_en    = 1'b1;
            end
            S_H2: w_ctrl.hash_fold = 1'b1;
            S_T: begin
                w_mul_a        = r_hash ^ r_cmd.data;
                w_ctrl.prod_en = 1'b1;
            end
            S_F1: begin
                w_mul_a        = w_fin_x ^ (w_fin_x >> FinShiftA);
                w_ctrl.prod_en = 1'b1;
            end
            S_F2: w_ctrl.out_load = w_out_free;
            default: w_ctrl = '0;
        endcase
    end

    assign o_q_pop = w_ctrl.pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hash      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ctrl.pop && i_q_cmd.start) begin
                r_hash <= i_q_cmd.init;
            end else if (w_ctrl.hash_fold) begin
                r_hash <= r_prod ^ r_k;
            end
            if (w_ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.pop) begin
            r_cmd <= i_q_cmd;
        end
        if (w_ctrl.prod_en) begin
            r_prod <= w_prod;
        end
        if (w_ctrl.k_en) begin
            r_k <= r_prod;
        end
        if (w_ctrl.out_load) begin
            r_out_hash <= w_result;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.hash_value = r_out_hash;

endmodule

`default_nettype wire

@@ rtl/murmur2_byte_stream_hash.sv @@
// MurmurHash2 (32-bit) over a byte stream, one byte per input beat. A beat
// with first_item set starts a message: the running hash becomes hash_seed
// XOR msg_len, where hash_seed is the register at APB address 0. Bytes are
// gathered into little-endian words, and each word is mixed and folded in.
// The beat with last_item set mixes in any tail bytes, runs the finalisation
// and yields one result beat carrying hash_value; other beats yield nothing.
// A beat with has_byte clear carries no byte, which is how an empty message
// is sent. The front end takes one byte beat per cycle while the queue
// is not full and places commands in a queue of QUEUE_DEPTH entries; the
// back end runs them through a single 32x32 multiplier, one command at a
// time. A completed word passes through the states S_K1, S_K2, S_H1 and
// S_H2. The final result is formed in S_F1 and S_F2 after its command
// leaves the queue (after S_T first with a tail, after the word states
// first when the last byte completes a word), later if the previous result
// is still waiting, and the output register lets the next message be taken
// while a result still waits. hash_seed must only be written while idle.
`default_nettype none

module murmur2_byte_stream_hash import mbsh_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    mbsh_item_if.sink                i_item,
    mbsh_result_if.source            o_result,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ApbAddrW-1:0] paddr,
    input  wire logic [WordW-1:0]    pwdata,
    output logic      [WordW-1:0]    prdata,
    output logic                     pready
);

    // The seed is the only register; every write to it completes at once.
    logic [WordW-1:0] r_seed;
    logic             w_seed_wr;

    assign pready    = 1'b1;
    assign w_seed_wr = psel && penable && pwrite && (paddr[ApbAddrW-1:2] == RegIdxHashSeed);
    assign prdata    = (paddr[ApbAddrW-1:2] == RegIdxHashSeed) ? r_seed : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (w_seed_wr) begin
            r_seed <= pwdata;
        end
    end

    // Command queue between the byte gatherer and the mixing sequencer.
    logic q_push, q_full, q_pop, q_valid;
    t_cmd q_wr_cmd, q_rd_cmd;

    mbsh_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_seed   (r_seed),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_cmd  (q_wr_cmd)
    );

    mbsh_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_wr_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_rd_cmd)
    );

    mbsh_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_rd_cmd),
        .o_q_pop   (q_pop),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire
